FILE: hw/rtl/local_vol_grid_interpolator_defines.svh
// Assertion macros shared by the local vol grid interpolator RTL.
`ifndef LOCAL_VOL_GRID_INTERPOLATOR_DEFINES_SVH
`define LOCAL_VOL_GRID_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LVGI_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lvgi: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define LVGI_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lvgi: next-cycle check failed");

`endif

FILE: hw/rtl/lvgi_pkg.sv
// Types and constants shared by the local vol grid interpolator modules.
`timescale 1ns / 1ps

package lvgi_pkg;

  // Request command codes
  typedef enum logic [1:0] {
    CMD_GRID_WR = 2'd0,
    CMD_DATE_WR = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_t;

  localparam int FRAC_BITS    = 24;
  localparam int LOG_SQ_STEPS = 24;
  // log unit: lead-one stage, shift stage, squaring stages, two ln stages
  localparam int LOG_LAT      = LOG_SQ_STEPS + 4;
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
  // 16.0 in Q.24, removes the Q16.16 scaling of the spot
  localparam logic signed [29:0] LOG2_BIAS = 30'sd268435456;
  localparam int VOL_W   = 32;
  localparam int SLOPE_W = 48;

endpackage

FILE: hw/rtl/lvgi_log.sv
// Pipelined natural log of an unsigned Q16.16 spot, result signed Q6.24.
`timescale 1ns / 1ps
`include "local_vol_grid_interpolator_defines.svh"

module lvgi_log
  import lvgi_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [31:0]         spot,
  output logic signed [29:0]  ln,
  output logic                zero
);

  // position of the leading one
  function automatic logic [4:0] lead_one(input logic [31:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

  logic        a_vld, a_zero;
  logic [31:0] a_spot;
  logic [4:0]  a_p;

  logic [31:0]          sq_m    [0:LOG_SQ_STEPS];
  logic [FRAC_BITS-1:0] sq_f    [0:LOG_SQ_STEPS];
  logic [4:0]           sq_p    [0:LOG_SQ_STEPS];
  logic                 sq_zero [0:LOG_SQ_STEPS];
  logic                 sq_vld  [0:LOG_SQ_STEPS];

  logic signed [29:0] d_log2;
  logic [28:0]        d_mag;
  logic               c_vld, c_neg, c_zero;
  logic [60:0]        c_prod;
  logic [61:0]        c_round;
  logic [28:0]        c_r;

  // lead-one detect
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= in_valid;
    end
    a_spot <= spot;
    a_p    <= lead_one(spot);
    a_zero <= (spot == '0);
  end

  // normalize mantissa to Q1.31
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else begin
      sq_vld[0] <= a_vld;
    end
    sq_m[0]    <= a_spot << (5'd31 - a_p);
    sq_f[0]    <= '0;
    sq_p[0]    <= a_p;
    sq_zero[0] <= a_zero;
  end

  // one fraction bit per squaring stage
  for (genvar k = 0; k < LOG_SQ_STEPS; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    logic [FRAC_BITS-1:0] f_next;
    assign sq = {32'b0, sq_m[k]} * {32'b0, sq_m[k]};
    assign t  = sq[63:31];
    assign f_next = sq_f[k] | (FRAC_BITS'(t[32]) << (FRAC_BITS - 1 - k));

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else begin
        sq_vld[k+1] <= sq_vld[k];
      end
      sq_m[k+1]    <= t[32] ? t[32:1] : t[31:0];
      sq_f[k+1]    <= f_next;
      sq_p[k+1]    <= sq_p[k];
      sq_zero[k+1] <= sq_zero[k];
    end

    `LVGI_ASSERT_IMP(a_norm, clk, rst, sq_vld[k+1] && !sq_zero[k+1], sq_m[k+1][31])
  end

  // log2 to ln: magnitude times ln 2
  assign d_log2 = $signed({1'b0, sq_p[LOG_SQ_STEPS], sq_f[LOG_SQ_STEPS]}) - LOG2_BIAS;
  assign d_mag  = d_log2[29] ? 29'(-d_log2) : d_log2[28:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= sq_vld[LOG_SQ_STEPS];
    end
    c_prod <= 61'(d_mag) * 61'(LN2_Q32);
    c_neg  <= d_log2[29];
    c_zero <= sq_zero[LOG_SQ_STEPS];
  end

  // round half away from zero, restore sign
  assign c_round = {1'b0, c_prod} + (62'd1 << 31);
  assign c_r     = c_round[60:32];

  always_ff @(posedge clk) begin
    ln   <= c_neg ? -$signed({1'b0, c_r}) : $signed({1'b0, c_r});
    zero <= c_zero;
  end

  `LVGI_ASSERT_NXT(a_neg_sign, clk, rst, c_vld && c_neg && (c_r != '0), ln < 30'sd0)

endmodule

FILE: hw/rtl/local_vol_grid_interpolator.sv
// Top level of the local vol grid interpolator: tables, log unit, interpolation.
// A query's done rises after the request register, the log unit, stages p1 to p6.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// The 24-stage squaring chain of the log unit sets most of the latency.
// Reset clears the pipeline valid bits only; grid and date tables keep contents.
`timescale 1ns / 1ps
`include "local_vol_grid_interpolator_defines.svh"

module local_vol_grid_interpolator
  import lvgi_pkg::*;
#(
  parameter int DATE_SLOTS = 64,
  parameter int GRID_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                command,
  input  logic [5:0]                date,
  input  logic [7:0]                grid_index,
  input  logic [31:0]               word_value,
  input  logic signed [15:0]        grid_offset,
  input  logic [8:0]                grid_points,
  input  logic [31:0]               spot,
  output logic                      done,
  output logic [VOL_W-1:0]          local_vol,
  output logic signed [SLOPE_W-1:0] vol_slope
);

  localparam int GRID_WORDS = DATE_SLOTS * GRID_DEPTH;
  localparam int AW  = $clog2(GRID_WORDS);
  localparam int DAW = (DATE_SLOTS > 1) ? $clog2(DATE_SLOTS) : 1;
  localparam int LW  = $clog2(GRID_DEPTH);
  localparam int FW  = 42;
  localparam int TOTAL_LAT = LOG_LAT + 8;

  typedef struct packed {
    logic               vld;
    logic               qry;
    logic               gwr;
    logic               date_ok;
    logic [7:0]         gidx;
    logic [31:0]        word;
    logic [AW-1:0]      base;
    logic [31:0]        inv;
    logic signed [15:0] off;
    logic [LW-1:0]      last;
  } it_t;

  logic accept;
  logic [DAW-1:0] date_idx;
  logic in_date_ok;

  // date tables
  logic [31:0]        inv_mem [0:DATE_SLOTS-1];
  logic signed [15:0] off_mem [0:DATE_SLOTS-1];
  logic [8:0]         pts_mem [0:DATE_SLOTS-1];
  logic [31:0]        inv_rd;
  logic signed [15:0] off_rd;
  logic [8:0]         pts_rd;

  // grid copies: one for the interpolation pair, one for the slope pair
  logic [31:0] gmem_a [0:GRID_WORDS-1];
  logic [31:0] gmem_b [0:GRID_WORDS-1];

  logic          s0_vld, s0_qry, s0_gwr, s0_date_ok;
  logic [7:0]    s0_gidx;
  logic [31:0]   s0_word, s0_spot;
  logic [AW-1:0] s0_base;
  logic [12:0]   s0_n;
  it_t           s0_item;

  it_t dl [1:LOG_LAT];
  logic signed [29:0] log_ln;
  logic               log_zero;

  it_t p1, p2, p3, p4, p5, p6;
  logic signed [62:0]    p1_prod;
  logic                  p1_zero;
  logic signed [FW-1:0]  p2_f;
  logic                  p2_zero;

  // index stage
  logic                  x_below, x_high, x_slope_en;
  logic signed [FW-1:0]  x_lim;
  logic [17:0]           x_fint;
  logic [LW-1:0]         x_int, x_last_m1, x_fi;
  logic [LW-1:0]         p3_ia, p3_ib, p3_fc0, p3_fc1;
  logic [FRAC_BITS-1:0]  p3_w;
  logic                  p3_slope_en;

  logic [31:0]           p4_va, p4_vb, p4_vc0, p4_vc1;
  logic [FRAC_BITS-1:0]  p4_w;
  logic                  p4_slope_en;

  logic [24:0]           y_wa;
  logic signed [32:0]    y_diff;
  logic [56:0]           p5_pa, p5_pb;
  logic [31:0]           p5_mag;
  logic                  p5_neg, p5_slope_en;

  logic [57:0]           z_acc;
  logic [31:0]           p6_vol;
  logic [63:0]           p6_sprod;
  logic                  p6_neg, p6_slope_en;

  logic [64:0]           o_round;
  logic [39:0]           o_r;

  assign busy       = 1'b0;
  assign accept     = start && !busy;
  assign date_idx   = DAW'(date);
  assign in_date_ok = 32'(date) < DATE_SLOTS;

  // date table write and read, at request acceptance
  always_ff @(posedge clk) begin
    if (accept && command == CMD_DATE_WR && in_date_ok) begin
      inv_mem[date_idx] <= word_value;
      off_mem[date_idx] <= grid_offset;
      pts_mem[date_idx] <= grid_points;
    end
    inv_rd <= inv_mem[date_idx];
    off_rd <= off_mem[date_idx];
    pts_rd <= pts_mem[date_idx];
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else begin
      s0_vld <= accept;
    end
    s0_qry     <= command == CMD_QUERY;
    s0_gwr     <= command == CMD_GRID_WR && in_date_ok && 32'(grid_index) < GRID_DEPTH;
    s0_date_ok <= in_date_ok;
    s0_gidx    <= grid_index;
    s0_word    <= word_value;
    s0_spot    <= spot;
    s0_base    <= AW'(32'(date_idx) * GRID_DEPTH);
  end

  // point count clamped to 1..GRID_DEPTH
  always_comb begin
    if (pts_rd == '0) begin
      s0_n = 13'd1;
    end else if (32'(pts_rd) > GRID_DEPTH) begin
      s0_n = 13'(GRID_DEPTH);
    end else begin
      s0_n = 13'(pts_rd);
    end
    s0_item = '{vld: s0_vld, qry: s0_qry, gwr: s0_gwr, date_ok: s0_date_ok,
                gidx: s0_gidx, word: s0_word, base: s0_base, inv: inv_rd,
                off: off_rd, last: LW'(s0_n - 13'd1)};
  end

  lvgi_log u_log (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s0_vld),
    .spot     (s0_spot),
    .ln       (log_ln),
    .zero     (log_zero)
  );

  // side fields wait for the log unit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LOG_LAT; k++) dl[k].vld <= 1'b0;
    end else begin
      dl[1] <= s0_item;
      for (int k = 2; k <= LOG_LAT; k++) dl[k] <= dl[k-1];
    end
  end

  // ln times inverse step
  always_ff @(posedge clk) begin
    if (rst) begin
      p1.vld <= 1'b0;
    end else begin
      p1 <= dl[LOG_LAT];
    end
    p1_prod <= 63'(log_ln) * 63'($signed({1'b0, dl[LOG_LAT].inv}));
    p1_zero <= log_zero;
  end

  // fractional grid index
  always_ff @(posedge clk) begin
    if (rst) begin
      p2.vld <= 1'b0;
    end else begin
      p2 <= p1;
    end
    p2_f    <= FW'(p1_prod >>> FRAC_BITS) - (FW'($signed(p1.off)) <<< FRAC_BITS);
    p2_zero <= p1_zero;
  end

  // clamp and split into entry indices and weight
  always_comb begin
    x_lim      = FW'(p2.last) << FRAC_BITS;
    x_below    = p2_zero || (p2_f <= 42'sd0);
    x_high     = !x_below && (p2_f >= x_lim);
    x_int      = p2_f[FRAC_BITS +: LW];
    x_fint     = p2_f[FW-1:FRAC_BITS];
    x_last_m1  = p2.last - 1'b1;
    x_slope_en = p2.last >= LW'(2);
    if (!x_slope_en || x_below || x_fint < 18'd1) begin
      x_fi = LW'(1);
    end else if (x_fint > 18'(x_last_m1)) begin
      x_fi = x_last_m1;
    end else begin
      x_fi = x_fint[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3.vld <= 1'b0;
    end else begin
      p3 <= p2;
    end
    if (x_below) begin
      p3_ia <= '0;
      p3_ib <= '0;
      p3_w  <= '0;
    end else if (x_high) begin
      p3_ia <= p2.last;
      p3_ib <= p2.last;
      p3_w  <= '0;
    end else begin
      p3_ia <= x_int;
      p3_ib <= x_int + 1'b1;
      p3_w  <= p2_f[FRAC_BITS-1:0];
    end
    p3_fc0      <= x_fi - 1'b1;
    p3_fc1      <= x_fi + 1'b1;
    p3_slope_en <= x_slope_en;
  end

  // grid write and read; writes stay in request order with the reads
  always_ff @(posedge clk) begin
    if (p3.vld && p3.gwr) begin
      gmem_a[p3.base + AW'(p3.gidx)] <= p3.word;
      gmem_b[p3.base + AW'(p3.gidx)] <= p3.word;
    end
    p4_va  <= gmem_a[p3.base + AW'(p3_ia)];
    p4_vb  <= gmem_a[p3.base + AW'(p3_ib)];
    p4_vc0 <= gmem_b[p3.base + AW'(p3_fc0)];
    p4_vc1 <= gmem_b[p3.base + AW'(p3_fc1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p4.vld <= 1'b0;
    end else begin
      p4 <= p3;
    end
    p4_w        <= p3_w;
    p4_slope_en <= p3_slope_en;
  end

  // weighted products and slope difference
  assign y_wa   = 25'(1 << FRAC_BITS) - 25'(p4_w);
  assign y_diff = $signed({1'b0, p4_vc1}) - $signed({1'b0, p4_vc0});

  always_ff @(posedge clk) begin
    if (rst) begin
      p5.vld <= 1'b0;
    end else begin
      p5 <= p4;
    end
    p5_pa       <= 57'(y_wa) * 57'(p4_va);
    p5_pb       <= 57'(p4_w) * 57'(p4_vb);
    p5_mag      <= y_diff[32] ? 32'(-y_diff) : y_diff[31:0];
    p5_neg      <= y_diff[32];
    p5_slope_en <= p4_slope_en;
  end

  // vol sum and slope product
  assign z_acc = 58'(p5_pa) + 58'(p5_pb) + (58'd1 << (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      p6.vld <= 1'b0;
    end else begin
      p6 <= p5;
    end
    p6_vol      <= z_acc[FRAC_BITS +: VOL_W];
    p6_sprod    <= 64'(p5_mag) * 64'(p5.inv);
    p6_neg      <= p5_neg;
    p6_slope_en <= p5_slope_en;
  end

  // slope rounding; magnitude stays below 2^40, so the 48-bit range holds it
  assign o_round = 65'(p6_sprod) + (65'd1 << FRAC_BITS);
  assign o_r     = o_round[64:25];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p6.vld && p6.qry;
    end
    if (p6.date_ok) begin
      local_vol <= p6_vol;
    end else begin
      local_vol <= '0;
    end
    if (p6.date_ok && p6_slope_en) begin
      vol_slope <= p6_neg ? -$signed(SLOPE_W'(o_r)) : $signed(SLOPE_W'(o_r));
    end else begin
      vol_slope <= '0;
    end
  end

  `LVGI_ASSERT_IMP(a_done_lat, clk, rst, done, $past(start && !busy && command == CMD_QUERY, TOTAL_LAT))
  `LVGI_ASSERT_IMP(a_pair_idx, clk, rst, p3.vld && p3.qry && p3.date_ok, (p3_ia <= p3.last) && ((p3_w == '0) || (p3_ib == p3_ia + 1'b1)))
  `LVGI_ASSERT_NXT(a_short_slope, clk, rst, p6.vld && p6.qry && !p6_slope_en, done && (vol_slope == '0))

endmodule
